// ===== design/bus_servo_command_framer_assert.svh =====
// Assertion macros for the servo command framer.
// Used by the top level; expands to nothing under synthesis.
`ifndef BUS_SERVO_COMMAND_FRAMER_ASSERT_SVH
`define BUS_SERVO_COMMAND_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define BSCF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bscf: same-cycle check failed");
`define BSCF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bscf: next-cycle check failed");
`else
`define BSCF_ASSERT_SAME(name, clk, rst, ante, cons)
`define BSCF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== design/bscf_pkg.sv =====
// Shared types and constants for the servo command framer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bscf_pkg;

   localparam int IdxW = 4;

   localparam logic [7:0] HEADER_BYTE   = 8'h55;
   localparam logic [7:0] LEN_NO_PARAM  = 8'd3;
   localparam logic [7:0] LEN_ONE_PARAM = 8'd5;
   localparam logic [7:0] LEN_TWO_PARAM = 8'd7;

   localparam logic [IdxW-1:0] IDX_HDR0 = 4'd0;
   localparam logic [IdxW-1:0] IDX_HDR1 = 4'd1;
   localparam logic [IdxW-1:0] IDX_ID   = 4'd2;
   localparam logic [IdxW-1:0] IDX_LEN  = 4'd3;
   localparam logic [IdxW-1:0] IDX_CMD  = 4'd4;
   localparam logic [IdxW-1:0] IDX_P1L  = 4'd5;
   localparam logic [IdxW-1:0] IDX_P1H  = 4'd6;
   localparam logic [IdxW-1:0] IDX_P2L  = 4'd7;
   localparam logic [IdxW-1:0] IDX_P2H  = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   typedef struct packed {
      logic            busy;
      logic            step;
      logic            last;
      logic [IdxW-1:0] idx;
   } seq_ctrl_type;

endpackage
`default_nettype wire

// ===== design/bscf_seq.sv =====
// Byte sequencer: walks the packet index one byte per free output slot.
// Depends on bscf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bscf_seq (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire                             out_free,
   input  wire  [bscf_pkg::IdxW-1:0]       last_idx,
   output bscf_pkg::seq_ctrl_type          ctrl
);

   bscf_pkg::state_type         state_ff, state_in;
   logic [bscf_pkg::IdxW-1:0]   idx_ff, idx_in;
   logic                        step;
   logic                        last;

   assign step = (state_ff == bscf_pkg::ST_SEND) && out_free;
   assign last = (idx_ff == last_idx);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         bscf_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bscf_pkg::ST_SEND;
               idx_in   = bscf_pkg::IDX_HDR0;
            end
         end
         bscf_pkg::ST_SEND: begin
            if (step) begin
               if (last) begin
                  state_in = bscf_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = bscf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bscf_pkg::ST_IDLE;
         idx_ff   <= bscf_pkg::IDX_HDR0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign ctrl.busy = (state_ff == bscf_pkg::ST_SEND);
   assign ctrl.step = step;
   assign ctrl.last = last;
   assign ctrl.idx  = idx_ff;

endmodule
`default_nettype wire

// ===== design/bscf_acc.sv =====
// 8-bit adder accumulating the packet checksum, one byte per step.
// Depends on bscf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bscf_acc (
   input  wire                     clock,
   input  bscf_pkg::seq_ctrl_type  ctrl,
   input  wire  [7:0]              data,
   output logic [7:0]              sum
);

   logic [7:0] sum_ff, sum_in;
   logic       body;

   assign body = ctrl.step && !ctrl.last && (ctrl.idx >= bscf_pkg::IDX_ID);

   always_comb begin
      sum_in = sum_ff;
      if (body) begin
         sum_in = (ctrl.idx == bscf_pkg::IDX_ID) ? data : sum_ff + data;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule
`default_nettype wire

// ===== design/bus_servo_command_framer.sv =====
// Servo bus command framer: one command item in, 6/8/10 packet bytes out.
// Throughput: one byte per cycle while rsp_tready holds; 6 + 2n bytes per item for n
// parameters, and the next item is accepted only once the sequencer is back in idle.
// Reset: synchronous, active high; clears sequencer and output valid.
// Depends on bscf_pkg, bscf_seq, bscf_acc.
`timescale 1ns / 1ps
`default_nettype none
module bus_servo_command_framer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // dest_id[7:0], command_code[15:8], param_count[17:16],
   // first_param[33:18], second_param[49:34], zero pad[55:50]
   input  wire  [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // frame_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   bscf_pkg::seq_ctrl_type      ctrl;
   logic                        start;
   logic                        out_free;
   logic [1:0]                  count;

   logic [7:0]                  id_ff, cmd_ff, len_ff;
   logic [15:0]                 p1_ff, p2_ff;
   logic [bscf_pkg::IdxW-1:0]   last_idx_ff;
   logic [7:0]                  len_in;
   logic [bscf_pkg::IdxW-1:0]   last_idx_in;

   logic [7:0]                  byte_sel;
   logic [7:0]                  sum;

   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_data_ff;
   logic                        rsp_last_ff;

   assign req_tready = !ctrl.busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count      = req_tdata[17:16];

   always_comb begin
      if (count == 2'd0) begin
         len_in      = bscf_pkg::LEN_NO_PARAM;
         last_idx_in = bscf_pkg::IDX_P1L;
      end else if (count == 2'd1) begin
         len_in      = bscf_pkg::LEN_ONE_PARAM;
         last_idx_in = bscf_pkg::IDX_P2L;
      end else begin
         len_in      = bscf_pkg::LEN_TWO_PARAM;
         last_idx_in = bscf_pkg::IDX_P2H + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         id_ff       <= req_tdata[7:0];
         cmd_ff      <= req_tdata[15:8];
         p1_ff       <= req_tdata[33:18];
         p2_ff       <= req_tdata[49:34];
         len_ff      <= len_in;
         last_idx_ff <= last_idx_in;
      end
   end

   bscf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .last_idx (last_idx_ff),
      .ctrl     (ctrl)
   );

   always_comb begin
      if (ctrl.last) begin
         byte_sel = ~sum;
      end else begin
         case (ctrl.idx)
            bscf_pkg::IDX_HDR0: byte_sel = bscf_pkg::HEADER_BYTE;
            bscf_pkg::IDX_HDR1: byte_sel = bscf_pkg::HEADER_BYTE;
            bscf_pkg::IDX_ID:   byte_sel = id_ff;
            bscf_pkg::IDX_LEN:  byte_sel = len_ff;
            bscf_pkg::IDX_CMD:  byte_sel = cmd_ff;
            bscf_pkg::IDX_P1L:  byte_sel = p1_ff[7:0];
            bscf_pkg::IDX_P1H:  byte_sel = p1_ff[15:8];
            bscf_pkg::IDX_P2L:  byte_sel = p2_ff[7:0];
            bscf_pkg::IDX_P2H:  byte_sel = p2_ff[15:8];
            default:            byte_sel = ~sum;
         endcase
      end
   end

   bscf_acc u_acc (
      .clock (clock),
      .ctrl  (ctrl),
      .data  (byte_sel),
      .sum   (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         rsp_data_ff <= byte_sel;
         rsp_last_ff <= ctrl.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `include "bus_servo_command_framer_assert.svh"

   `BSCF_ASSERT_NEXT(a_busy_after_accept, clock, reset, start, !req_tready)
   `BSCF_ASSERT_NEXT(a_header_first, clock, reset,
      ctrl.step && (ctrl.idx == bscf_pkg::IDX_HDR0),
      rsp_tvalid && (rsp_tdata == bscf_pkg::HEADER_BYTE) && !rsp_tlast)
   `BSCF_ASSERT_SAME(a_idx_bounded, clock, reset, ctrl.busy, ctrl.idx <= last_idx_ff)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for bus_servo_command_framer: drives command items and checks every
// packet byte and its end flag against a built-in packet builder.
// Depends on bscf_pkg and the framer RTL only.
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] PCOUNT_NONE = 2'd0;
   localparam logic [1:0] PCOUNT_ONE  = 2'd1;
   localparam logic [1:0] PCOUNT_TWO  = 2'd2;
   localparam logic [1:0] PCOUNT_SAT  = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 450;
   localparam int REPORT_MAX   = 10;

   typedef enum logic [1:0] {
      SINK_ALWAYS,
      SINK_RANDOM,
      SINK_BURSTY
   } sink_mode_type;

   typedef struct packed {
      logic [7:0]  dest_id;
      logic [7:0]  command_code;
      logic [1:0]  param_count;
      logic [15:0] first_param;
      logic [15:0] second_param;
   } command_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } packet_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   packet_byte_type packet_bytes_due[$];
   sink_mode_type   sink_mode = SINK_ALWAYS;
   bit              source_gaps = 1'b1;
   int              burst_left = 0;
   int              sink_hold = 0;
   int              cycles = 0;
   int              mismatches = 0;
   int              bytes_checked = 0;
   int              commands_sent = 0;
   int              count_hits[4] = '{0, 0, 0, 0};

   bus_servo_command_framer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Builds the packet for one command; a count of three saturates to two.
   function automatic void build_packet(command_type c);
      logic [7:0] body[7];
      logic [7:0] sum;
      int         n;
      int         nparams;
      nparams = (c.param_count > PCOUNT_TWO) ? 2 : int'(c.param_count);
      body[0] = c.dest_id;
      body[1] = (nparams == 0) ? bscf_pkg::LEN_NO_PARAM :
                (nparams == 1) ? bscf_pkg::LEN_ONE_PARAM : bscf_pkg::LEN_TWO_PARAM;
      body[2] = c.command_code;
      body[3] = c.first_param[7:0];
      body[4] = c.first_param[15:8];
      body[5] = c.second_param[7:0];
      body[6] = c.second_param[15:8];
      n = 3 + 2 * nparams;
      sum = 8'd0;
      packet_bytes_due.push_back('{bscf_pkg::HEADER_BYTE, 1'b0});
      packet_bytes_due.push_back('{bscf_pkg::HEADER_BYTE, 1'b0});
      for (int i = 0; i < n; i++) begin
         sum = sum + body[i];
         packet_bytes_due.push_back('{body[i], 1'b0});
      end
      packet_bytes_due.push_back('{~sum, 1'b1});
   endfunction

   task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch %s at cycle %0d: expected %02h, got %02h", what, cycles, want, got);
   endtask

   always @(posedge clock) begin : check_bytes
      packet_byte_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (packet_bytes_due.size() == 0) begin
            note_mismatch("unexpected byte", 8'h00, rsp_tdata);
         end else begin
            want = packet_bytes_due.pop_front();
            bytes_checked++;
            if (rsp_tdata !== want.frame_byte)
               note_mismatch("frame byte", want.frame_byte, rsp_tdata);
            if (rsp_tlast !== want.last_byte)
               note_mismatch("last flag", {7'd0, want.last_byte}, {7'd0, rsp_tlast});
         end
      end
   end

   always @(posedge clock) begin
      if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (sink_mode)
            SINK_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            SINK_RANDOM: begin
               rsp_tready <= ($urandom_range(3) != 0);
            end
            default: begin
               if ($urandom_range(11) == 0) begin
                  sink_hold <= $urandom_range(12, 1);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic send_command(command_type c);
      req_tdata <= {6'd0, c.second_param, c.first_param, c.param_count,
                    c.command_code, c.dest_id};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      build_packet(c);
      commands_sent++;
      count_hits[c.param_count]++;
      if (source_gaps) begin
         if (burst_left <= 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clock);
            burst_left = $urandom_range(8, 1);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic pause_source();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (packet_bytes_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_param();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed_packets();
      sink_mode = SINK_ALWAYS;
      source_gaps = 1'b0;
      send_command('{8'h00, 8'h00, PCOUNT_NONE, 16'h0000, 16'h0000});
      send_command('{8'hFF, 8'hFF, PCOUNT_NONE, 16'hFFFF, 16'hFFFF});
      send_command('{8'h01, 8'h0B, PCOUNT_ONE, 16'h0000, 16'hFFFF});
      send_command('{8'hFE, 8'hFF, PCOUNT_ONE, 16'hFFFF, 16'h1234});
      send_command('{8'hAA, 8'h55, PCOUNT_ONE, 16'h00FF, 16'h0000});
      send_command('{8'h55, 8'hAA, PCOUNT_ONE, 16'hFF00, 16'hFFFF});
      send_command('{8'hFF, 8'hFF, PCOUNT_TWO, 16'hFFFF, 16'hFFFF});
      send_command('{8'h00, 8'h00, PCOUNT_TWO, 16'h0000, 16'h0000});
      send_command('{8'h12, 8'h01, PCOUNT_TWO, 16'hAAAA, 16'h5555});
      send_command('{8'h34, 8'h1C, PCOUNT_TWO, 16'h5555, 16'hAAAA});
      // count of three behaves as two
      send_command('{8'hFE, 8'h07, PCOUNT_SAT, 16'h03E8, 16'h01F4});
      send_command('{8'hFF, 8'hFF, PCOUNT_SAT, 16'hFFFF, 16'hFFFF});
      send_command('{8'h00, 8'h00, PCOUNT_SAT, 16'h0000, 16'h0000});
      // unused parameters must stay out of the packet and checksum
      send_command('{8'h7F, 8'h80, PCOUNT_NONE, 16'hDEAD, 16'hBEEF});
      send_command('{8'h80, 8'h7F, PCOUNT_ONE, 16'h8001, 16'hCAFE});
      pause_source();
      wait_drained();
   endtask

   task automatic test_random_traffic(int n, sink_mode_type mode);
      command_type c;
      sink_mode = mode;
      source_gaps = 1'b1;
      for (int i = 0; i < n; i++) begin
         c.dest_id      = 8'($urandom);
         c.command_code = 8'($urandom);
         c.param_count  = 2'($urandom_range(3));
         c.first_param  = pick_param();
         c.second_param = pick_param();
         send_command(c);
      end
      pause_source();
   endtask

   task automatic test_back_to_back(int n);
      command_type c;
      sink_mode = SINK_ALWAYS;
      source_gaps = 1'b0;
      for (int i = 0; i < n; i++) begin
         c = command_type'({$urandom, $urandom});
         send_command(c);
      end
      pause_source();
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_packets();
      test_back_to_back(20);
      test_random_traffic(RANDOM_ITEMS / 3, SINK_RANDOM);
      wait_drained();
      test_random_traffic(RANDOM_ITEMS / 3, SINK_BURSTY);
      test_random_traffic(RANDOM_ITEMS / 3, SINK_ALWAYS);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d commands (param count 0/1/2/3: %0d/%0d/%0d/%0d), checked %0d bytes",
               commands_sent, count_hits[0], count_hits[1], count_hits[2], count_hits[3],
               bytes_checked);
      $display("Mismatches: %0d; source gaps and sink stalls varied across phases",
               mismatches);
      if (mismatches == 0 && packet_bytes_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
